// ===== rtl/assert_macros.svh =====
// Assertion macros, included by sha256_stream_hasher.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg)
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/sha256_pkg.sv =====
// Package for the SHA-256 stream hasher: constants, command/status types,
// round constant table and round functions. No dependencies.
package sha256_pkg;

    typedef logic [31:0] t_word;

    localparam t_word IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    // Byte source selected by the controller when writing the block buffer
    localparam logic [1:0] SRC_DATA = 2'd0;
    localparam logic [1:0] SRC_PAD  = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;
    localparam logic [1:0] SRC_LEN  = 2'd3;

    typedef struct packed {
        logic       wr_en;      // write one byte to the block buffer
        logic [1:0] wr_src;
        logic       add_bits;   // add 8 to the bit count
        logic       start;      // begin a compression of the buffer
        logic       init;       // restart chaining state and counters
        logic       load_out;   // capture digest word for output
        logic [2:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic       busy;       // compression in progress
        logic [5:0] fill;       // next write position
    } t_sts;

    function automatic t_word round_k(input logic [5:0] i);
        t_word k;
        unique case (i)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word sig0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word sig1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word bsig0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ===== rtl/sha256_if.sv =====
// Valid/ready stream interfaces for the hasher's input and digest channels.
// Uses no package.
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_of_message;
    modport source (output valid, data_byte, byte_present, last_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, last_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/sha256_dp.sv =====
// Datapath: block buffer, message schedule window, round registers,
// chaining state and bit count. Driven by sha256_ctrl through sha256_pkg types.
module sha256_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha256_pkg::t_cmd    i_cmd,
    input  logic [7:0]          i_byte,
    output sha256_pkg::t_sts    o_sts,
    output logic [31:0]         o_word
);
    logic [7:0]  r_buf [64];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    sha256_pkg::t_word r_h [8];
    sha256_pkg::t_word r_v [8];
    sha256_pkg::t_word r_w [16];
    logic        r_busy;
    logic        r_loading;
    logic        r_fold;
    logic [5:0]  r_rnd;
    logic [5:0]  r_ld;
    logic [31:0] r_word;

    logic [7:0]  wr_byte;
    sha256_pkg::t_word w_cur, w_new, t1, t2;
    logic [2:0]  len_sel;

    assign len_sel = r_fill[2:0];

    always_comb begin
        unique case (i_cmd.wr_src)
            sha256_pkg::SRC_DATA: wr_byte = i_byte;
            sha256_pkg::SRC_PAD:  wr_byte = sha256_pkg::PAD_BYTE;
            sha256_pkg::SRC_ZERO: wr_byte = 8'h00;
            sha256_pkg::SRC_LEN:  wr_byte = r_bits[8 * (7 - len_sel) +: 8];
            default:              wr_byte = 8'h00;
        endcase
    end

    // Schedule window: slot 0 is w[t]; next word from the sliding window
    assign w_new = sha256_pkg::sig1(r_w[14]) + r_w[9] + sha256_pkg::sig0(r_w[1]) + r_w[0];
    assign w_cur = r_w[0];
    assign t1 = r_v[7] + sha256_pkg::bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + sha256_pkg::round_k(r_rnd) + w_cur;
    assign t2 = sha256_pkg::bsig0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // Buffer is a memory: one write from the controller, one read while loading
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_buf[r_fill] <= wr_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_bits    <= '0;
            r_busy    <= 1'b0;
            r_loading <= 1'b0;
            r_fold    <= 1'b0;
            r_rnd     <= '0;
            r_ld      <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::IV[i];
        end else begin
            if (i_cmd.wr_en) r_fill <= r_fill + 6'd1;
            if (i_cmd.add_bits) r_bits <= r_bits + 64'd8;
            if (i_cmd.init) begin
                r_fill <= '0;
                r_bits <= '0;
                for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::IV[i];
            end
            if (i_cmd.start) begin
                r_busy    <= 1'b1;
                r_loading <= 1'b1;
                r_fold    <= 1'b0;
                r_ld      <= '0;
                r_rnd     <= '0;
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end else if (r_loading) begin
                // shift bytes into the window, big-endian
                for (int i = 0; i < 15; i++) r_w[i] <= {r_w[i][23:0], r_w[i + 1][31:24]};
                r_w[15] <= {r_w[15][23:0], r_buf[r_ld]};
                r_ld <= r_ld + 6'd1;
                if (r_ld == 6'd63) r_loading <= 1'b0;
            end else if (r_fold) begin
                // working variables now hold the last round: fold them in
                r_fold <= 1'b0;
                r_busy <= 1'b0;
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end else if (r_busy) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                r_w[15] <= w_new;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_rnd  <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) r_fold <= 1'b1;
            end
        end
    end

    // Digest word register; the controller loads it only once busy has dropped
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) r_word <= r_h[i_cmd.out_idx];
    end

    assign o_word     = r_word;
    assign o_sts.busy = r_busy;
    assign o_sts.fill = r_fill;
endmodule

// ===== rtl/sha256_ctrl.sv =====
// Controller: accepts beats, sequences padding, compression and digest output.
// Depends on sha256_pkg and sha256_if.
module sha256_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sha256_in_if.sink          in_ch,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [2:0]         o_out_idx,
    input  sha256_pkg::t_sts   i_sts,
    output sha256_pkg::t_cmd   o_cmd
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WAIT  = 3'd1;  // compression of a data block
    localparam logic [2:0] ST_PAD   = 3'd2;  // write 0x80
    localparam logic [2:0] ST_FILL  = 3'd3;  // zeros / length, then compress
    localparam logic [2:0] ST_FWAIT = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_OHOLD = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_last, n_last;   // end pending after current compression
    logic       r_final, n_final; // padding: block carries the length; ST_WAIT: start issued
    logic [2:0] r_idx, n_idx;
    logic       r_ovalid, n_ovalid;
    logic       acc;

    assign in_ch.ready = (r_state == ST_IDLE);
    assign acc         = in_ch.valid && in_ch.ready;
    assign o_out_valid = r_ovalid;
    assign o_out_idx   = r_idx;

    always_comb begin
        n_state  = r_state;
        n_last   = r_last;
        n_final  = r_final;
        n_idx    = r_idx;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (in_ch.byte_present) begin
                        o_cmd.wr_en    = 1'b1;
                        o_cmd.wr_src   = sha256_pkg::SRC_DATA;
                        o_cmd.add_bits = 1'b1;
                    end
                    n_last = in_ch.last_of_message;
                    if (in_ch.byte_present && i_sts.fill == 6'd63) begin
                        n_state = ST_WAIT;
                    end else if (in_ch.last_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_WAIT: begin
                // the fill has already wrapped when this state is entered; start here once
                if (!i_sts.busy && !r_final) begin
                    o_cmd.start = 1'b1;
                    n_final     = 1'b1;
                end else if (!i_sts.busy && r_final) begin
                    n_final = 1'b0;
                    n_state = r_last ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = sha256_pkg::SRC_PAD;
                if (i_sts.fill == 6'd63) begin
                    // pad closes the block: compress it, length goes in the next
                    o_cmd.start = 1'b1;
                    n_final     = 1'b0;
                    n_state     = ST_FWAIT;
                end else begin
                    n_final = (i_sts.fill < sha256_pkg::LEN_POS);
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = (r_final && i_sts.fill >= sha256_pkg::LEN_POS) ?
                               sha256_pkg::SRC_LEN : sha256_pkg::SRC_ZERO;
                if (i_sts.fill == 6'd63) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_FWAIT;
                end
            end
            ST_FWAIT: begin
                if (!i_sts.busy) begin
                    if (r_final) begin
                        n_final = 1'b0;
                        n_state = ST_OUT;
                    end else begin
                        // spilled padding: one more block of zeros and length
                        n_final = 1'b1;
                        n_state = ST_FILL;
                    end
                end
            end
            ST_OUT: begin
                o_cmd.load_out = 1'b1;
                o_cmd.out_idx  = r_idx;
                n_ovalid       = 1'b1;
                n_state        = ST_OHOLD;
            end
            ST_OHOLD: begin
                if (i_out_ready) begin
                    n_ovalid = 1'b0;
                    n_idx    = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.init = 1'b1;
                        n_last     = 1'b0;
                        n_state    = ST_IDLE;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_last   <= 1'b0;
            r_final  <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_last   <= n_last;
            r_final  <= n_final;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end
endmodule

// ===== rtl/sha256_stream_hasher.sv =====
// SHA-256 stream hasher. At most one byte per accepted beat; a beat that
// fills a 64-byte block holds input off while the block is started, loaded
// into the schedule window, put through 64 rounds of the single round unit
// and folded into chaining state; the controller then idles, or pads if last.
// A last beat adds padding writes, one or two block compressions, then
// eight digest beats, each one waiting until the sink has taken the last.
// Depends on sha256_pkg, sha256_if, sha256_ctrl, sha256_dp, assert_macros.svh.
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha256_in_if.sink   in_ch,
    sha256_out_if.source out_ch
);
`include "assert_macros.svh"
    sha256_pkg::t_cmd cmd;
    sha256_pkg::t_sts sts;
    logic [31:0]      word;
    logic [2:0]       idx;

    sha256_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .i_out_ready (out_ch.ready),
        .o_out_valid (out_ch.valid),
        .o_out_idx   (idx),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sha256_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_byte  (in_ch.data_byte),
        .o_sts   (sts),
        .o_word  (word)
    );

    assign out_ch.digest_word = word;
    assign out_ch.word_index  = idx;
    assign out_ch.last_word   = (idx == 3'd7);

    `CHK_IMPL(a_no_in_busy, i_clk, i_rst_n, sts.busy, !in_ch.ready, "input taken while busy")
    `CHK_IMPL(a_no_out_busy, i_clk, i_rst_n, out_ch.valid, !sts.busy, "digest while busy")
    `CHK_NEXT(a_wrap, i_clk, i_rst_n, out_ch.valid && out_ch.ready && out_ch.last_word,
              sts.fill == 6'd0, "state not restarted")
endmodule
